>>> rtl/core/brb_pkg.sv
// Shared types, constants and ring arithmetic for the byte ring buffer.
// Used by every module under rtl/core except brb_ram; depends on nothing.
`default_nettype none

package brb_pkg;

  localparam int unsigned STORE_DEPTH = 1024;
  localparam int unsigned MAX_RUN     = 64;
  localparam int unsigned CMD_DEPTH   = 2;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned OPC_W  = 3;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned CAP_W  = 10;
  localparam int unsigned IDX_W  = $clog2(STORE_DEPTH);
  localparam int unsigned SUM_W  = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;
  localparam int unsigned PEND_W = $clog2(CMD_DEPTH + 2);

  // Usable capacity is limited so that the ring never spans more than the store.
  localparam int unsigned CAP_LIMIT = STORE_DEPTH - 1;
  localparam int unsigned CAP_RESET = (CAP_LIMIT < 1023) ? CAP_LIMIT : 1023;

  typedef enum logic [OPC_W-1:0] {
    OP_PUT   = 3'd0,
    OP_GET   = 3'd1,
    OP_PEEK  = 3'd2,
    OP_ERASE = 3'd3,
    OP_CLEAR = 3'd4
  } op_e;

  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [BYTE_W-1:0] data_in;
    logic [LEN_W-1:0]  request_length;
  } brb_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    logic              data_valid;
    logic [LEN_W-1:0]  moved_count;
    logic [CAP_W-1:0]  stored_count;
    logic [CAP_W-1:0]  free_count;
    logic              last;
  } brb_out_t;

  // Work handed from the front to the back through the command queue.
  typedef struct packed {
    logic             is_run;
    logic [IDX_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] moved;
    logic [CAP_W-1:0] stored;
    logic [CAP_W-1:0] free;
  } brb_cmd_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } brb_wr_t;

  typedef struct packed {
    logic run_done;
  } brb_stat_t;

  // Advance a ring index by n slots; the ring spans cap + 1 slots.
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] idx,
                                                input logic [LEN_W-1:0] n,
                                                input logic [CAP_W-1:0] cap);
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] span;
    sum  = SUM_W'(idx) + SUM_W'(n);
    span = SUM_W'(cap) + SUM_W'(1);
    if (sum >= span) begin
      sum = sum - span;
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/byte_ring_buffer.sv
// Byte ring buffer top level: an accepted item is queued as a command, and the back
// end registers its first result on the output channel. Single-result items (put,
// erase, clear, empty reads) sustain one per cycle while no run holds the back end and
// out_ready_i is high; a get or peek run of n bytes holds the back end for n store
// reads, one per byte, and a put waits until no get or peek run is queued or reading.
// Reset (async, active low) empties the ring and sets capacity to 1023; store
// contents are undefined until written and there is no clearing pass.
`default_nettype none

module byte_ring_buffer import brb_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire brb_in_t          in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output brb_out_t              out_data_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CAP_W-1:0] cfg_data_i
);

  logic              cmd_push;
  logic              cmd_full;
  logic              cmd_pop;
  logic              cmd_valid;
  brb_cmd_t          cmd_in;
  brb_cmd_t          cmd_out;
  brb_stat_t         stat;
  brb_wr_t           ram_wr;
  logic [CAP_W-1:0]  cap;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  brb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in),
    .cmd_full_i  (cmd_full),
    .stat_i      (stat),
    .ram_wr_o    (ram_wr),
    .cap_o       (cap)
  );

  brb_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_out)
  );

  brb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .cap_i       (cap),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .stat_o      (stat)
  );

  brb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_wr.en),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

>>> rtl/core/brb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
`default_nettype none

module brb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/brb_cmd_fifo.sv
// Short command queue between the front and the back of the byte ring buffer.
// Depends on brb_pkg for the command type and depth.
`default_nettype none

module brb_cmd_fifo import brb_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire brb_cmd_t cmd_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          valid_o,
  output brb_cmd_t      cmd_o
);

  localparam int unsigned PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(CMD_DEPTH + 1);

  brb_cmd_t          mem_q [CMD_DEPTH];
  logic [PTR_W-1:0]  wp_q, wp_d;
  logic [PTR_W-1:0]  rp_q, rp_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(CMD_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    wp_d  = push_i ? ptr_next(wp_q) : wp_q;
    rp_d  = pop_i ? ptr_next(rp_q) : rp_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

  assign full_o  = (cnt_q == CNT_W'(CMD_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rp_q];

endmodule

`default_nettype wire

>>> rtl/core/brb_front.sv
// Front end: accepts items and configuration, keeps the ring indices and
// counts, writes put bytes to the store and queues commands for the back.
// Depends on brb_pkg.
`default_nettype none

module brb_front import brb_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire brb_in_t          in_data_i,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CAP_W-1:0] cfg_data_i,
  output logic                  cmd_push_o,
  output brb_cmd_t              cmd_o,
  input  wire logic             cmd_full_i,
  input  wire brb_stat_t        stat_i,
  output brb_wr_t               ram_wr_o,
  output logic      [CAP_W-1:0] cap_o
);

  logic [CAP_W-1:0]  cap_q, cap_d;
  logic [CAP_W-1:0]  held_q, held_d;
  logic [IDX_W-1:0]  rd_q, rd_d;
  logic [IDX_W-1:0]  wr_q, wr_d;
  logic [PEND_W-1:0] pend_q, pend_d;
  logic [LEN_W-1:0]  req_c;
  logic [LEN_W-1:0]  n_c;
  logic              room_c;
  logic              in_fire;
  logic              cfg_fire;

  // Hold puts while a read run is outstanding: a freed slot may still be unread.
  assign in_ready_o  = !cmd_full_i &&
                       !((in_data_i.opcode == OP_PUT) && (pend_q != '0));
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;
  assign cmd_push_o  = in_fire;
  assign cap_o       = cap_q;

  assign req_c  = (in_data_i.request_length > LEN_W'(MAX_RUN)) ? LEN_W'(MAX_RUN)
                                                               : in_data_i.request_length;
  assign n_c    = (SUM_W'(held_q) < SUM_W'(req_c)) ? LEN_W'(held_q) : req_c;
  assign room_c = (held_q != cap_q);

  always_comb begin
    cap_d  = cap_q;
    held_d = held_q;
    rd_d   = rd_q;
    wr_d   = wr_q;

    cmd_o.is_run = 1'b0;
    cmd_o.start  = rd_q;
    cmd_o.len    = n_c;
    cmd_o.moved  = '0;

    ram_wr_o.en   = 1'b0;
    ram_wr_o.addr = wr_q;
    ram_wr_o.data = in_data_i.data_in;

    case (in_data_i.opcode)
      OP_PUT: begin
        if (room_c) begin
          cmd_o.moved = LEN_W'(1);
          if (in_fire) begin
            ram_wr_o.en = 1'b1;
            held_d      = held_q + CAP_W'(1);
            wr_d        = ring_add(wr_q, LEN_W'(1), cap_q);
          end
        end
      end
      OP_GET: begin
        cmd_o.is_run = (n_c != '0);
        cmd_o.moved  = n_c;
        if (in_fire) begin
          rd_d   = ring_add(rd_q, n_c, cap_q);
          held_d = held_q - CAP_W'(n_c);
        end
      end
      OP_PEEK: begin
        cmd_o.is_run = (n_c != '0);
        cmd_o.moved  = n_c;
      end
      OP_ERASE: begin
        cmd_o.moved = n_c;
        if (in_fire) begin
          rd_d   = ring_add(rd_q, n_c, cap_q);
          held_d = held_q - CAP_W'(n_c);
        end
      end
      OP_CLEAR: begin
        if (in_fire) begin
          rd_d   = '0;
          wr_d   = '0;
          held_d = '0;
        end
      end
      default: begin
      end
    endcase

    cmd_o.stored = held_d;
    cmd_o.free   = cap_q - held_d;

    // A capacity write empties the ring.
    if (cfg_fire) begin
      if (SUM_W'(cfg_data_i) > SUM_W'(CAP_LIMIT)) begin
        cap_d = CAP_W'(CAP_LIMIT);
      end else begin
        cap_d = cfg_data_i;
      end
      held_d = '0;
      rd_d   = '0;
      wr_d   = '0;
    end

    pend_d = pend_q;
    if ((in_fire && cmd_o.is_run) && !stat_i.run_done) begin
      pend_d = pend_q + PEND_W'(1);
    end else if (!(in_fire && cmd_o.is_run) && stat_i.run_done) begin
      pend_d = pend_q - PEND_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CAP_W'(CAP_RESET);
      held_q <= '0;
      rd_q   <= '0;
      wr_q   <= '0;
      pend_q <= '0;
    end else begin
      cap_q  <= cap_d;
      held_q <= held_d;
      rd_q   <= rd_d;
      wr_q   <= wr_d;
      pend_q <= pend_d;
    end
  end

  a_held_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= cap_q)
    else $error("stored count exceeds capacity");

  a_idx_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SUM_W'(rd_q) <= SUM_W'(cap_q)) && (SUM_W'(wr_q) <= SUM_W'(cap_q)))
    else $error("ring index outside the ring span");

  a_put_no_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_wr_o.en |-> (pend_q == '0))
    else $error("store written while a read run is outstanding");

  a_run_done_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.run_done |-> (pend_q != '0))
    else $error("read run finished with none outstanding");

endmodule

`default_nettype wire

>>> rtl/core/brb_back.sv
// Back end: takes commands from the queue, reads run bytes from the store and
// drives the result channel. The store's read register is the output data stage.
// Depends on brb_pkg.
`default_nettype none

module brb_back import brb_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  input  wire brb_cmd_t          cmd_i,
  output logic                   cmd_pop_o,
  input  wire logic [CAP_W-1:0]  cap_i,
  output logic                   ram_re_o,
  output logic      [IDX_W-1:0]  ram_raddr_o,
  input  wire logic [BYTE_W-1:0] ram_rdata_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output brb_out_t               out_data_o,
  output brb_stat_t              stat_o
);

  logic             busy_q, busy_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [LEN_W-1:0] remain_q, remain_d;
  brb_cmd_t         meta_q, meta_d;
  logic             ov_q, ov_d;
  logic             odv_q, odv_d;
  logic [LEN_W-1:0] omoved_q, omoved_d;
  logic [CAP_W-1:0] ostored_q, ostored_d;
  logic [CAP_W-1:0] ofree_q, ofree_d;
  logic             olast_q, olast_d;
  logic             adv;
  logic             fin;

  assign adv = !ov_q || out_ready_i;

  always_comb begin
    busy_d      = busy_q;
    rd_idx_d    = rd_idx_q;
    remain_d    = remain_q;
    meta_d      = meta_q;
    ov_d        = ov_q && !out_ready_i;
    odv_d       = odv_q;
    omoved_d    = omoved_q;
    ostored_d   = ostored_q;
    ofree_d     = ofree_q;
    olast_d     = olast_q;
    cmd_pop_o   = 1'b0;
    ram_re_o    = 1'b0;
    ram_raddr_o = rd_idx_q;
    stat_o      = '0;
    fin         = 1'b0;

    if (adv) begin
      if (busy_q) begin
        // Continue the run: one byte per transfer.
        fin         = (remain_q == LEN_W'(1));
        ram_re_o    = 1'b1;
        ram_raddr_o = rd_idx_q;
        ov_d        = 1'b1;
        odv_d       = 1'b1;
        omoved_d    = fin ? meta_q.len : '0;
        ostored_d   = meta_q.stored;
        ofree_d     = meta_q.free;
        olast_d     = fin;
        busy_d      = !fin;
        rd_idx_d    = ring_add(rd_idx_q, LEN_W'(1), cap_i);
        remain_d    = remain_q - LEN_W'(1);
        stat_o.run_done = fin;
      end else if (cmd_valid_i) begin
        cmd_pop_o = 1'b1;
        meta_d    = cmd_i;
        ov_d      = 1'b1;
        ostored_d = cmd_i.stored;
        ofree_d   = cmd_i.free;
        if (cmd_i.is_run) begin
          fin         = (cmd_i.len == LEN_W'(1));
          ram_re_o    = 1'b1;
          ram_raddr_o = cmd_i.start;
          odv_d       = 1'b1;
          omoved_d    = fin ? cmd_i.len : '0;
          olast_d     = fin;
          busy_d      = !fin;
          rd_idx_d    = ring_add(cmd_i.start, LEN_W'(1), cap_i);
          remain_d    = cmd_i.len - LEN_W'(1);
          stat_o.run_done = fin;
        end else begin
          odv_d    = 1'b0;
          omoved_d = cmd_i.moved;
          olast_d  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_idx_d;
    remain_q  <= remain_d;
    meta_q    <= meta_d;
    odv_q     <= odv_d;
    omoved_q  <= omoved_d;
    ostored_q <= ostored_d;
    ofree_q   <= ofree_d;
    olast_q   <= olast_d;
  end

  assign out_valid_o             = ov_q;
  assign out_data_o.data_out     = odv_q ? ram_rdata_i : '0;
  assign out_data_o.data_valid   = odv_q;
  assign out_data_o.moved_count  = omoved_q;
  assign out_data_o.stored_count = ostored_q;
  assign out_data_o.free_count   = ofree_q;
  assign out_data_o.last         = olast_q;

  a_busy_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (remain_q != '0))
    else $error("run in progress with no bytes left");

  a_no_pop_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !cmd_pop_o)
    else $error("command taken while a run is in progress");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for byte_ring_buffer: directed and random requests
// through valid/ready channels, checked against an in-bench ring predictor.
// Depends on brb_pkg and the byte_ring_buffer top level.
`default_nettype none

module tb_top;
  import brb_pkg::*;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid;
  logic             in_ready;
  brb_in_t          in_data;
  logic             out_valid;
  logic             out_ready;
  brb_out_t         out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data;

  // Predictor state
  logic [BYTE_W-1:0] ring_mirror [STORE_DEPTH];
  int unsigned       ring_capacity;
  int unsigned       rd_pos;
  int unsigned       wr_pos;
  brb_out_t          pending_results [$];

  int unsigned error_count;
  int unsigned results_checked;
  int unsigned requests_sent;
  int unsigned capacity_writes;
  int unsigned stall_request;
  bit          tx_idle;
  bit          rx_idle;

  byte_ring_buffer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic int unsigned fill_level(input int unsigned span);
    if (wr_pos >= rd_pos) begin
      return wr_pos - rd_pos;
    end
    return span - (rd_pos - wr_pos);
  endfunction

  // Update the ring copy for one accepted request and queue its results.
  function automatic void ring_apply(input brb_in_t item);
    int unsigned span;
    int unsigned used;
    int unsigned req;
    int unsigned n;
    int unsigned moved;
    int unsigned idx;
    int unsigned free_slots;
    bit          is_read;
    brb_out_t    r;
    span    = ring_capacity + 1;
    used    = fill_level(span);
    req     = (item.request_length > MAX_RUN) ? MAX_RUN : item.request_length;
    n       = (used < req) ? used : req;
    moved   = 0;
    idx     = rd_pos;
    is_read = 1'b0;
    case (item.opcode)
      OP_PUT: begin
        if (span - 1 - used > 0) begin
          ring_mirror[wr_pos] = item.data_in;
          wr_pos = (wr_pos + 1) % span;
          moved  = 1;
        end
      end
      OP_GET, OP_PEEK: begin
        moved   = n;
        is_read = (n != 0);
        if (item.opcode == OP_GET) begin
          rd_pos = (rd_pos + n) % span;
        end
      end
      OP_ERASE: begin
        moved  = n;
        rd_pos = (rd_pos + n) % span;
      end
      OP_CLEAR: begin
        rd_pos = 0;
        wr_pos = 0;
      end
      default: ;
    endcase
    used       = fill_level(span);
    free_slots = span - 1 - used;
    r = '0;
    r.stored_count = CAP_W'(used);
    r.free_count   = CAP_W'(free_slots);
    if (is_read) begin
      for (int unsigned i = 0; i < n; i++) begin
        r.data_out    = ring_mirror[idx];
        r.data_valid  = 1'b1;
        r.last        = (i + 1 == n);
        r.moved_count = r.last ? LEN_W'(n) : '0;
        pending_results.push_back(r);
        idx = (idx + 1) % span;
      end
    end else begin
      r.moved_count = LEN_W'(moved);
      r.last        = 1'b1;
      pending_results.push_back(r);
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_val,
                                      input int unsigned act_val);
    if (exp_val != act_val) begin
      if (error_count < 40) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val,
                 act_val);
      end
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    brb_out_t exp_r;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        if (error_count < 40) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, out_data);
        end
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("data_out", exp_r.data_out, out_data.data_out);
        check_field("data_valid", exp_r.data_valid, out_data.data_valid);
        check_field("moved_count", exp_r.moved_count, out_data.moved_count);
        check_field("stored_count", exp_r.stored_count, out_data.stored_count);
        check_field("free_count", exp_r.free_count, out_data.free_count);
        check_field("last", exp_r.last, out_data.last);
        results_checked++;
      end
    end
  end

  // Result side: random hold-off per transfer when rx_idle is set, plus a long stall on request.
  initial begin
    int unsigned gap;
    out_ready = 1'b0;
    wait (rst_ni);
    forever begin
      gap = rx_idle ? $urandom_range(0, 15) : 0;
      if (stall_request > 0) begin
        gap = stall_request;
        stall_request = 0;
      end
      if (gap > 0) begin
        @(negedge clk_i);
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
    end
  end

  task automatic send_item(input brb_in_t item);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    ring_apply(item);
    requests_sent++;
  endtask

  task automatic send_request(input op_e op, input int unsigned data,
                              input int unsigned len);
    brb_in_t item;
    item.opcode         = op;
    item.data_in        = BYTE_W'(data);
    item.request_length = LEN_W'(len);
    send_item(item);
  endtask

  task automatic stop_input();
    @(negedge clk_i);
    in_valid <= 1'b0;
  endtask

  task automatic wait_results_drained();
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Write the capacity only with the input quiet and every result delivered.
  task automatic set_capacity(input int unsigned cap);
    stop_input();
    wait_results_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= CAP_W'(cap);
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    ring_capacity = cap;
    rd_pos = 0;
    wr_pos = 0;
    capacity_writes++;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic brb_in_t random_item();
    brb_in_t     item;
    int unsigned pick;
    int unsigned len_pick;
    pick     = $urandom_range(0, 99);
    len_pick = $urandom_range(0, 99);
    item.data_in = BYTE_W'($urandom_range(0, 255));
    if (len_pick < 80) begin
      item.request_length = LEN_W'($urandom_range(0, 12));
    end else if (len_pick < 95) begin
      item.request_length = LEN_W'($urandom_range(13, 64));
    end else begin
      item.request_length = LEN_W'($urandom_range(65, 127));
    end
    if (pick < 45) begin
      item.opcode = OP_PUT;
    end else if (pick < 65) begin
      item.opcode = OP_GET;
    end else if (pick < 77) begin
      item.opcode = OP_PEEK;
    end else if (pick < 88) begin
      item.opcode = OP_ERASE;
    end else if (pick < 93) begin
      item.opcode = OP_CLEAR;
    end else begin
      item.opcode = OPC_W'($urandom_range(5, 7));
    end
    return item;
  endfunction

  task automatic test_empty_and_basic_ops();
    brb_in_t item;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_request(OP_GET, 8'h11, 5);
    send_request(OP_PEEK, 8'h22, 5);
    send_request(OP_ERASE, 8'h33, 5);
    send_request(OP_PUT, 8'h00, 0);
    send_request(OP_PUT, 8'hFF, 127);
    send_request(OP_PUT, 8'hA5, 0);
    send_request(OP_PEEK, 8'h00, 0);
    send_request(OP_PEEK, 8'h00, 127);
    send_request(OP_GET, 8'h00, 2);
    send_request(OP_ERASE, 8'h00, 127);
    // Undefined opcodes leave the ring alone.
    for (int unsigned op = 5; op <= 7; op++) begin
      item.opcode         = OPC_W'(op);
      item.data_in        = 8'h5A;
      item.request_length = LEN_W'(3);
      send_item(item);
    end
    send_request(OP_CLEAR, 8'h00, 0);
  endtask

  task automatic test_zero_capacity();
    set_capacity(0);
    send_request(OP_PUT, 8'h5A, 0);
    send_request(OP_GET, 8'h00, 4);
    send_request(OP_ERASE, 8'h00, 4);
    send_request(OP_CLEAR, 8'h00, 0);
  endtask

  task automatic test_full_ring();
    set_capacity(2);
    send_request(OP_PUT, 8'h81, 0);
    send_request(OP_PUT, 8'h7E, 0);
    send_request(OP_PUT, 8'hC3, 0);
    send_request(OP_GET, 8'h00, 127);
    send_request(OP_PUT, 8'h3C, 0);
  endtask

  task automatic test_output_backpressure();
    set_capacity(CAP_RESET);
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    stall_request = 300;
    for (int i = 0; i < 100; i++) begin
      send_request(OP_PUT, $urandom_range(0, 255), 0);
    end
    send_request(OP_PEEK, 8'h00, 127);
    send_request(OP_GET, 8'h00, 127);
    send_request(OP_GET, 8'h00, 127);
  endtask

  task automatic test_random_traffic();
    int unsigned caps [10];
    caps = '{1, 3, 8, 1023, 17, 2, 1, 5, 64, 1};
    caps[6] = $urandom_range(1, 40);
    for (int p = 0; p < 10; p++) begin
      set_capacity(caps[p]);
      tx_idle = ($urandom_range(0, 3) != 0) && (p != 4);
      rx_idle = ($urandom_range(0, 3) != 0) && (p != 4);
      repeat (38) send_item(random_item());
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    ring_capacity   = CAP_RESET;
    rd_pos          = 0;
    wr_pos          = 0;
    error_count     = 0;
    results_checked = 0;
    requests_sent   = 0;
    capacity_writes = 0;
    stall_request   = 0;
    tx_idle         = 1'b1;
    rx_idle         = 1'b1;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_and_basic_ops();
    test_zero_capacity();
    test_full_ring();
    test_output_backpressure();
    test_random_traffic();

    stop_input();
    wait_results_drained();
    repeat (8) @(posedge clk_i);
    $display("Ran %0d requests and checked %0d results over %0d capacity writes,",
             requests_sent, results_checked, capacity_writes);
    $display("including empty, zero-capacity and full rings and a long output stall.");
    if (error_count == 0) begin
      $display("** byte_ring_buffer: PASSED **");
    end else begin
      $display("** byte_ring_buffer: FAILED **");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("Timeout with %0d results still outstanding", pending_results.size());
    $display("** byte_ring_buffer: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
